@@ design/segment_intersection_2d_macros.svh @@
// assertion helpers used by the top-level design file
`ifndef SEGMENT_INTERSECTION_2D_MACROS_SVH
`define SEGMENT_INTERSECTION_2D_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define SEGI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SEGI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/segi_pkg.sv @@
`timescale 1ns / 1ps

package segi_pkg;

	localparam int COORD_WIDTH_DEF = 32;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_NO_CROSS = 2'd2
	} status_t;

endpackage

@@ design/segi_div_step.sv @@
`timescale 1ns / 1ps

module segi_div_step #(
	parameter int MW = 66,
	parameter int QW = 33,
	parameter int SW = 68
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_ready,
	input  logic [MW-1:0] src_rem_x,
	input  logic [QW-1:0] src_qn_x,
	input  logic [MW-1:0] src_rem_y,
	input  logic [QW-1:0] src_qn_y,
	input  logic [MW-1:0] src_den,
	input  logic [SW-1:0] src_side,
	output logic          dst_valid,
	input  logic          dst_ready,
	output logic [MW-1:0] dst_rem_x,
	output logic [QW-1:0] dst_qn_x,
	output logic [MW-1:0] dst_rem_y,
	output logic [QW-1:0] dst_qn_y,
	output logic [MW-1:0] dst_den,
	output logic [SW-1:0] dst_side
);

	// one restoring step per lane: shift in the next dividend bit, subtract if it fits
	logic [MW:0]   trial_x, trial_y;
	logic          fit_x, fit_y;
	logic [MW-1:0] rem_nx, rem_ny;

	always_comb begin
		trial_x = {src_rem_x, src_qn_x[QW-1]};
		trial_y = {src_rem_y, src_qn_y[QW-1]};
		fit_x   = trial_x >= {1'b0, src_den};
		fit_y   = trial_y >= {1'b0, src_den};
		rem_nx  = fit_x ? MW'(trial_x - {1'b0, src_den}) : trial_x[MW-1:0];
		rem_ny  = fit_y ? MW'(trial_y - {1'b0, src_den}) : trial_y[MW-1:0];
	end

	assign src_ready = !dst_valid || dst_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else if (src_ready) begin
			dst_valid <= src_valid;
		end
	end

	// low dividend bits leave at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			dst_rem_x <= rem_nx;
			dst_rem_y <= rem_ny;
			dst_qn_x  <= {src_qn_x[QW-2:0], fit_x};
			dst_qn_y  <= {src_qn_y[QW-2:0], fit_y};
			dst_den   <= src_den;
			dst_side  <= src_side;
		end
	end

endmodule

@@ design/segment_intersection_2d.sv @@
// throughput: one transaction per cycle while out_ready stays high; every stage has its own valid bit and a stage
//   only holds when the stage after it is full and stalled
// depth is set by the quotient: one restoring-division stage per quotient bit
// reset: arst_n low clears every valid bit at once; payload registers are not reset
`timescale 1ns / 1ps
`include "segment_intersection_2d_macros.svh"

module segment_intersection_2d #(
	parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] a_x,
	input  logic signed [COORD_WIDTH-1:0] a_y,
	input  logic signed [COORD_WIDTH-1:0] b_x,
	input  logic signed [COORD_WIDTH-1:0] b_y,
	input  logic signed [COORD_WIDTH-1:0] c_x,
	input  logic signed [COORD_WIDTH-1:0] c_y,
	input  logic signed [COORD_WIDTH-1:0] d_x,
	input  logic signed [COORD_WIDTH-1:0] d_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] hit_x,
	output logic signed [COORD_WIDTH-1:0] hit_y,
	output logic [1:0]                    status
);

	import segi_pkg::*;

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;          // coordinate difference
	localparam int PW   = 2 * DW;         // one product of differences
	localparam int CW   = PW + 1;         // a cross product
	localparam int MW   = CW - 1;         // magnitude of a positive cross product
	localparam int HALF = (MW + 1) / 2;   // low slice of sn for the split multiply
	localparam int HW   = MW - HALF;      // high slice of sn
	localparam int QW   = DW;             // quotient bits, one division stage each
	localparam int NW   = DW + MW;        // dividend |span| * sn
	localparam int SW   = 2 * W + 4;      // sideband through the divider

	// ---------------------------------------------------------------
	// stage 1: endpoint differences relative to a, plus c - d
	// ---------------------------------------------------------------
	logic                 v_s1, rdy_s1;
	logic signed [DW-1:0] abx_s1, aby_s1, acx_s1, acy_s1;
	logic signed [DW-1:0] adx_s1, ady_s1, cdx_s1, cdy_s1;
	logic signed [W-1:0]  ax_s1, ay_s1;

	logic rdy_s2;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			abx_s1 <= DW'(b_x) - DW'(a_x);
			aby_s1 <= DW'(b_y) - DW'(a_y);
			acx_s1 <= DW'(c_x) - DW'(a_x);
			acy_s1 <= DW'(c_y) - DW'(a_y);
			adx_s1 <= DW'(d_x) - DW'(a_x);
			ady_s1 <= DW'(d_y) - DW'(a_y);
			cdx_s1 <= DW'(c_x) - DW'(d_x);
			cdy_s1 <= DW'(c_y) - DW'(d_y);
			ax_s1  <= a_x;
			ay_s1  <= a_y;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: the eight products behind det, sn, tn and den
	// ---------------------------------------------------------------
	logic                 v_s2;
	logic signed [PW-1:0] det0_s2, det1_s2, sn0_s2, sn1_s2;
	logic signed [PW-1:0] tn0_s2, tn1_s2, den0_s2, den1_s2;
	logic signed [DW-1:0] abx_s2, aby_s2;
	logic signed [W-1:0]  ax_s2, ay_s2;

	logic rdy_s3;
	assign rdy_s2 = !v_s2 || rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			det0_s2 <= abx_s1 * acy_s1;
			det1_s2 <= aby_s1 * acx_s1;
			sn0_s2  <= adx_s1 * acy_s1;
			sn1_s2  <= ady_s1 * acx_s1;
			tn0_s2  <= abx_s1 * ady_s1;
			tn1_s2  <= aby_s1 * adx_s1;
			den0_s2 <= abx_s1 * cdy_s1;
			den1_s2 <= aby_s1 * cdx_s1;
			abx_s2  <= abx_s1;
			aby_s2  <= aby_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: cross products
	// ---------------------------------------------------------------
	logic                 v_s3;
	logic signed [CW-1:0] det_s3, sn_s3, tn_s3, den_s3;
	logic signed [DW-1:0] abx_s3, aby_s3;
	logic signed [W-1:0]  ax_s3, ay_s3;

	logic rdy_s4;
	assign rdy_s3 = !v_s3 || rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			det_s3 <= CW'(det0_s2) - CW'(det1_s2);
			sn_s3  <= CW'(sn0_s2) - CW'(sn1_s2);
			tn_s3  <= CW'(tn0_s2) - CW'(tn1_s2);
			den_s3 <= CW'(den0_s2) - CW'(den1_s2);
			abx_s3 <= abx_s2;
			aby_s3 <= aby_s2;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: flip signs so det is positive, flag a zero det
	// ---------------------------------------------------------------
	logic                 v_s4, detz_s4;
	logic signed [CW-1:0] sn_s4, tn_s4, den_s4;
	logic signed [DW-1:0] abx_s4, aby_s4;
	logic signed [W-1:0]  ax_s4, ay_s4;

	logic rdy_s5;
	assign rdy_s4 = !v_s4 || rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			detz_s4 <= det_s3 == '0;
			sn_s4   <= det_s3[CW-1] ? -sn_s3 : sn_s3;
			tn_s4   <= det_s3[CW-1] ? -tn_s3 : tn_s3;
			den_s4  <= det_s3[CW-1] ? -den_s3 : den_s3;
			abx_s4  <= abx_s3;
			aby_s4  <= aby_s3;
			ax_s4   <= ax_s3;
			ay_s4   <= ay_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 5: classify, and split |span| * sn into two partial products
	// ---------------------------------------------------------------
	logic                 v_s5, neg_x_s5, neg_y_s5;
	status_t              st_s5;
	logic [DW+HALF-1:0]   pplo_x_s5, pplo_y_s5;
	logic [DW+HW-1:0]     pphi_x_s5, pphi_y_s5;
	logic [MW-1:0]        den_s5;
	logic signed [W-1:0]  ax_s5, ay_s5;

	logic [DW-1:0] mag_x, mag_y;
	logic [MW-1:0] sn_mag;
	status_t       st_c;

	always_comb begin
		mag_x  = abx_s4[DW-1] ? DW'(-abx_s4) : DW'(abx_s4);
		mag_y  = aby_s4[DW-1] ? DW'(-aby_s4) : DW'(aby_s4);
		sn_mag = sn_s4[MW-1:0];
		// a hit needs sn > 0, tn <= 0 and sn < den, both ends open
		if (detz_s4) begin
			st_c = ST_PARALLEL;
		end else if (sn_s4 <= 0 || tn_s4 > 0 || den_s4 <= sn_s4) begin
			st_c = ST_NO_CROSS;
		end else begin
			st_c = ST_HIT;
		end
	end

	logic rdy_s6;
	assign rdy_s5 = !v_s5 || rdy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			st_s5     <= st_c;
			pplo_x_s5 <= mag_x * sn_mag[HALF-1:0];
			pphi_x_s5 <= mag_x * sn_mag[MW-1:HALF];
			pplo_y_s5 <= mag_y * sn_mag[HALF-1:0];
			pphi_y_s5 <= mag_y * sn_mag[MW-1:HALF];
			neg_x_s5  <= abx_s4[DW-1];
			neg_y_s5  <= aby_s4[DW-1];
			den_s5    <= den_s4[MW-1:0];
			ax_s5     <= ax_s4;
			ay_s5     <= ay_s4;
		end
	end

	// ---------------------------------------------------------------
	// stage 6: full dividend; its top part already sits below den
	// ---------------------------------------------------------------
	logic                 v_s6;
	logic [MW-1:0]        rem_x_s6, rem_y_s6, den_s6;
	logic [QW-1:0]        qn_x_s6, qn_y_s6;
	logic [SW-1:0]        side_s6;

	logic [NW-1:0] num_x, num_y;

	always_comb begin
		num_x = NW'(pplo_x_s5) + (NW'(pphi_x_s5) << HALF);
		num_y = NW'(pplo_y_s5) + (NW'(pphi_y_s5) << HALF);
	end

	logic dv [0:QW];
	logic dr [0:QW];
	assign rdy_s6 = !v_s6 || dr[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (rdy_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			rem_x_s6 <= num_x[NW-1:QW];
			rem_y_s6 <= num_y[NW-1:QW];
			qn_x_s6  <= num_x[QW-1:0];
			qn_y_s6  <= num_y[QW-1:0];
			den_s6   <= den_s5;
			side_s6  <= {ax_s5, ay_s5, neg_x_s5, neg_y_s5, st_s5};
		end
	end

	// ---------------------------------------------------------------
	// division: one quotient bit per stage, both lanes side by side
	// ---------------------------------------------------------------
	logic [MW-1:0] drx [0:QW];
	logic [MW-1:0] dry [0:QW];
	logic [QW-1:0] dqx [0:QW];
	logic [QW-1:0] dqy [0:QW];
	logic [MW-1:0] dden [0:QW];
	logic [SW-1:0] dside [0:QW];

	assign dv[0]    = v_s6;
	assign drx[0]   = rem_x_s6;
	assign dry[0]   = rem_y_s6;
	assign dqx[0]   = qn_x_s6;
	assign dqy[0]   = qn_y_s6;
	assign dden[0]  = den_s6;
	assign dside[0] = side_s6;

	for (genvar k = 0; k < QW; k++) begin : g_div
		segi_div_step #(
			.MW(MW),
			.QW(QW),
			.SW(SW)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.src_valid (dv[k]),
			.src_ready (dr[k]),
			.src_rem_x (drx[k]),
			.src_qn_x  (dqx[k]),
			.src_rem_y (dry[k]),
			.src_qn_y  (dqy[k]),
			.src_den   (dden[k]),
			.src_side  (dside[k]),
			.dst_valid (dv[k+1]),
			.dst_ready (dr[k+1]),
			.dst_rem_x (drx[k+1]),
			.dst_qn_x  (dqx[k+1]),
			.dst_rem_y (dry[k+1]),
			.dst_qn_y  (dqy[k+1]),
			.dst_den   (dden[k+1]),
			.dst_side  (dside[k+1])
		);
	end

	// ---------------------------------------------------------------
	// round stage: half or more of den rounds away from zero, then sign
	// ---------------------------------------------------------------
	logic                 v_r, rdy_r;
	logic signed [DW-1:0] off_x_r, off_y_r;
	logic signed [W-1:0]  ax_r, ay_r;
	status_t              st_r;

	logic signed [W-1:0] side_ax, side_ay;
	logic                side_nx, side_ny;
	status_t             side_st;
	logic [QW-1:0]       qr_x, qr_y;

	always_comb begin
		side_ax = dside[QW][SW-1 -: W];
		side_ay = dside[QW][W+3 -: W];
		side_nx = dside[QW][3];
		side_ny = dside[QW][2];
		side_st = status_t'(dside[QW][1:0]);
		qr_x    = dqx[QW] + QW'({drx[QW], 1'b0} >= {1'b0, dden[QW]});
		qr_y    = dqy[QW] + QW'({dry[QW], 1'b0} >= {1'b0, dden[QW]});
	end

	logic rdy_o;
	assign dr[QW] = rdy_r;
	assign rdy_r  = !v_r || rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r <= 1'b0;
		end else if (rdy_r) begin
			v_r <= dv[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_r && dv[QW]) begin
			off_x_r <= side_nx ? -$signed(qr_x) : $signed(qr_x);
			off_y_r <= side_ny ? -$signed(qr_y) : $signed(qr_y);
			ax_r    <= side_ax;
			ay_r    <= side_ay;
			st_r    <= side_st;
		end
	end

	// ---------------------------------------------------------------
	// output register: a plus offset, zeroed when there is no hit
	// ---------------------------------------------------------------
	logic signed [DW-1:0] sum_x, sum_y;

	always_comb begin
		sum_x = DW'(ax_r) + off_x_r;
		sum_y = DW'(ay_r) + off_y_r;
	end

	assign rdy_o = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rdy_o) begin
			out_valid <= v_r;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && v_r) begin
			hit_x  <= (st_r == ST_HIT) ? sum_x[W-1:0] : '0;
			hit_y  <= (st_r == ST_HIT) ? sum_y[W-1:0] : '0;
			status <= st_r;
		end
	end

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	`SEGI_ASSERT_IMP(a_zero_on_miss, out_valid && status != ST_HIT, hit_x == '0 && hit_y == '0, "point not zero on a miss")
	`SEGI_ASSERT_IMP(a_rem_below_den, dv[QW] && side_st == ST_HIT, drx[QW] < dden[QW] && dry[QW] < dden[QW], "division remainder not below den")
	`SEGI_ASSERT_NXT(a_s1_loads, in_valid && in_ready, v_s1, "accepted transaction missing from stage 1")

endmodule

@@ sim/segment_intersection_2d_tb.sv @@
`timescale 1ns / 1ps

module segment_intersection_2d_tb;
	import segi_pkg::*;

	localparam int CW        = 32;
	localparam int LATENCY   = CW + 9;
	localparam int WDOG_MAX  = 3000;
	localparam int HOLD_LEN  = 300;

	// one segment pair as it is offered to the block
	typedef struct packed {
		logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
	} seg_pair_t;

	// one crossing result as the block should return it
	typedef struct packed {
		logic signed [CW-1:0] hx, hy;
		status_t              st;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CW-1:0] hit_x, hit_y;
	logic [1:0] status;
	seg_pair_t cur = '0;

	seg_pair_t pending_pairs[$];
	crossing_t expected_crossings[$];

	int err_cnt = 0;
	int n_hit = 0, n_par = 0, n_miss = 0;
	int in_idle_pct = 0, out_stall_pct = 0;
	logic start_hold = 1'b0;
	logic hold_taken = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;

	always #2 clk = ~clk;

	segment_intersection_2d #(.COORD_WIDTH(CW)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_x(cur.ax), .a_y(cur.ay), .b_x(cur.bx), .b_y(cur.by),
		.c_x(cur.cx), .c_y(cur.cy), .d_x(cur.dx), .d_y(cur.dy),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit_x(hit_x), .hit_y(hit_y), .status(status)
	);

	// round(span * num / den) to the nearest raw unit, ties away from zero; den > 0
	function automatic logic signed [127:0] scaled_offset(logic signed [127:0] span,
			logic signed [127:0] num, logic signed [127:0] den);
		logic signed [127:0] prod;
		logic [127:0] mag, quo, rem;
		prod = span * num;
		mag  = prod < 0 ? -prod : prod;
		quo  = mag / den;
		rem  = mag % den;
		if (2 * rem >= den) quo = quo + 1;
		return prod < 0 ? -$signed(quo) : $signed(quo);
	endfunction

	// where CD meets line AB, exact cross-product arithmetic at 128 bits
	function automatic crossing_t predict_crossing(seg_pair_t p);
		logic signed [127:0] ax, ay, abx, aby, acx, acy, adx, ady;
		logic signed [127:0] det, sn, tn, den;
		crossing_t r;
		ax  = p.ax;
		ay  = p.ay;
		abx = 128'(signed'(p.bx)) - ax;
		aby = 128'(signed'(p.by)) - ay;
		acx = 128'(signed'(p.cx)) - ax;
		acy = 128'(signed'(p.cy)) - ay;
		adx = 128'(signed'(p.dx)) - ax;
		ady = 128'(signed'(p.dy)) - ay;
		r = '{hx: '0, hy: '0, st: ST_HIT};
		det = abx * acy - aby * acx;
		if (det == 0) begin
			r.st = ST_PARALLEL;
			return r;
		end
		sn  = adx * acy - ady * acx;
		tn  = abx * ady - aby * adx;
		den = abx * (acy - ady) - aby * (acx - adx);
		if (det < 0) begin
			sn  = -sn;
			tn  = -tn;
			den = -den;
		end
		// cd must reach line ab strictly inside segment ab
		if (!(sn > 0) || tn > 0 || !(den - sn > 0)) begin
			r.st = ST_NO_CROSS;
			return r;
		end
		r.hx = CW'(ax + scaled_offset(abx, sn, den));
		r.hy = CW'(ay + scaled_offset(aby, sn, den));
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		err_cnt++;
	endtask

	function automatic logic signed [CW-1:0] rnd_coord(int span_bits);
		logic signed [CW-1:0] v;
		v = $urandom_range(0, (1 << span_bits) - 1);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// mostly pairs built to straddle ab, some noise across the full range
	function automatic seg_pair_t make_pair();
		seg_pair_t p;
		logic signed [CW-1:0] px, py, ux, uy;
		int k, f, bits;
		if ($urandom_range(0, 9) < 2) begin
			p = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			return p;
		end
		bits = $urandom_range(0, 3) == 0 ? 28 : $urandom_range(4, 24);
		p.ax = rnd_coord(bits);
		p.ay = rnd_coord(bits);
		p.bx = rnd_coord(bits);
		p.by = rnd_coord(bits);
		k  = $urandom_range(0, 16);
		px = p.ax + (p.bx - p.ax) / 16 * k;
		py = p.ay + (p.by - p.ay) / 16 * k;
		ux = rnd_coord(bits - 2);
		uy = rnd_coord(bits - 2);
		f  = $urandom_range(0, 3);
		p.cx = px + ux;
		p.cy = py + uy;
		p.dx = px - ux * f;
		p.dy = py - uy * f;
		if ($urandom_range(0, 4) == 0) begin
			// collinear or degenerate variant
			p.cx = p.ax;
			p.cy = p.ay;
		end
		return p;
	endfunction

	// driver: offer the next pending transaction, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_crossings.push_back(predict_crossing(cur));
			if (!in_valid || in_ready) begin
				if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
					cur      <= pending_pairs.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		crossing_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_crossings.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					e = expected_crossings.pop_front();
					if (status != e.st)
						report_mismatch($sformatf("status %0d want %0d", status, e.st));
					if (hit_x != e.hx)
						report_mismatch($sformatf("hit_x %h want %h", hit_x, e.hx));
					if (hit_y != e.hy)
						report_mismatch($sformatf("hit_y %h want %h", hit_y, e.hy));
					case (e.st)
						ST_HIT:      n_hit++;
						ST_PARALLEL: n_par++;
						default:     n_miss++;
					endcase
				end
			end
			// long hold-off so the pipeline fills and backs up into the input
			if (start_hold && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left  <= HOLD_LEN;
				out_ready  <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(0, 99) >= out_stall_pct;
			end
		end
	end

	// watchdog: cycles with work outstanding but no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(pending_pairs.size() == 0 && expected_crossings.size() == 0 && !in_valid))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("watchdog expired with %0d results outstanding", expected_crossings.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_pair(input logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy);
		pending_pairs.push_back('{ax, ay, bx, by, cx, cy, dx, dy});
	endtask

	task automatic drain();
		wait (pending_pairs.size() == 0 && !in_valid && expected_crossings.size() == 0);
	endtask

	localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: plain hit, det sign flipped, endpoint touching, parallel, no crossing
		push_pair(0, 0, 4 << 16, 0, 1 << 16, 1 << 16, 1 << 16, -(1 << 16));
		push_pair(0, 0, 4 << 16, 0, 1 << 16, -(1 << 16), 1 << 16, 1 << 16);
		push_pair(0, 0, 4 << 16, 0, 0, 1 << 16, 0, -(1 << 16));
		push_pair(0, 0, 4 << 16, 0, 4 << 16, 1 << 16, 4 << 16, -(1 << 16));
		push_pair(0, 0, 4 << 16, 0, 1 << 16, 1 << 16, 3 << 16, 1 << 16);
		push_pair(0, 0, 4 << 16, 0, 1 << 16, 2 << 16, 1 << 16, 1 << 16);
		push_pair(0, 0, 4 << 16, 0, 1 << 16, 1 << 16, 1 << 16, 0);
		push_pair(0, 0, 0, 0, 0, 0, 0, 0);
		push_pair(0, 0, 3, 0, 1, 1, 1, -2);
		push_pair(0, 0, 3, 0, 2, 1, 2, -1);
		push_pair(0, 0, 1, 0, 1, 1, 0, -1);
		push_pair(MINV, MINV, MAXV, MAXV, MINV, MAXV, MAXV, MINV);
		push_pair(MAXV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MINV);
		push_pair(MINV, 0, MAXV, 0, 0, MAXV, 0, MINV);
		push_pair(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
		push_pair(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
		push_pair(-1, -1, -1, -1, -1, -1, -1, -1);
		push_pair(MINV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV);
		push_pair(0, MINV, 0, MAXV, MINV, 0, MAXV, 1);
		drain();

		// random phases: no idling, sender idle, receiver stalling, both light
		for (int ph = 0; ph < 4; ph++) begin
			in_idle_pct   = (ph == 1) ? 57 : (ph == 3) ? 9 : 0;
			out_stall_pct = (ph == 2) ? 57 : (ph == 3) ? 9 : 0;
			for (int i = 0; i < 95; i++)
				pending_pairs.push_back(make_pair());
			drain();
		end

		// receiver holds off while the sender keeps offering
		in_idle_pct   = 0;
		out_stall_pct = 0;
		for (int i = 0; i < 70; i++)
			pending_pairs.push_back(make_pair());
		start_hold <= 1'b1;
		drain();

		repeat (LATENCY + 10) @(posedge clk);
		if (expected_crossings.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_crossings.size()));
		$display("covered %0d hits, %0d parallel or degenerate, %0d no-crossing pairs",
			n_hit, n_par, n_miss);
		$display("with input gaps, output stalls and a %0d-cycle output hold-off", HOLD_LEN);
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
